// ===== src/lkv_pkg.sv =====
`default_nettype none

package lkv_pkg;

	localparam int unsigned KEY_W    = 64;
	localparam int unsigned HANDLE_W = 32;

	// operation codes of a request beat
	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_ADD    = 2'd1,
		OP_CLEAR  = 2'd2
	} lkv_op_t;

	// request beat
	typedef struct packed {
		logic [1:0]          op;
		logic [KEY_W-1:0]    key;
		logic [HANDLE_W-1:0] image_handle;
	} lkv_req_t;

	// result beat
	typedef struct packed {
		logic                found;
		logic [HANDLE_W-1:0] result_handle;
		logic [KEY_W-1:0]    evicted_key;
	} lkv_rsp_t;

	// per-slot command from the control to a cell
	typedef struct packed {
		logic clr;
		logic take_prev;
		logic take_new;
	} lkv_cell_cmd_t;

	// per-slot compare flags from a cell to the control
	typedef struct packed {
		logic eq_key;
		logic eq_lru;
	} lkv_cell_stat_t;

endpackage

`default_nettype wire

// ===== src/lkv_cell.sv =====
`default_nettype none

module lkv_cell
	import lkv_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [KEY_W-1:0]    key,
	input  wire logic [KEY_W-1:0]    lru_key,
	input  wire logic [HANDLE_W-1:0] new_handle,
	input  wire logic [KEY_W-1:0]    prev_key,
	input  wire logic [HANDLE_W-1:0] prev_handle,
	input  wire lkv_cell_cmd_t       cmd,
	output lkv_cell_stat_t           stat,
	output logic [KEY_W-1:0]         slot_key,
	output logic [HANDLE_W-1:0]      slot_handle
);

	logic [KEY_W-1:0]    key_q;
	logic [HANDLE_W-1:0] handle_q;

	// compare against the request key and the least recent key
	assign stat.eq_key = (key_q == key);
	assign stat.eq_lru = (key_q == lru_key);

	assign slot_key    = key_q;
	assign slot_handle = handle_q;

	// slot storage: clear, take the neighbour's pair or take the new pair
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q    <= '0;
			handle_q <= '0;
		end else if (cmd.clr) begin
			key_q    <= '0;
			handle_q <= '0;
		end else if (cmd.take_prev) begin
			key_q    <= prev_key;
			handle_q <= prev_handle;
		end else if (cmd.take_new) begin
			key_q    <= key;
			handle_q <= new_handle;
		end
	end

endmodule

`default_nettype wire

// ===== src/lkv_ctrl.sv =====
`default_nettype none

module lkv_ctrl
	import lkv_pkg::*;
#(
	parameter int unsigned SLOTS = 4
) (
	input  wire logic                accept,
	input  wire lkv_req_t            req,
	input  wire lkv_cell_stat_t      stat [SLOTS],
	input  wire logic [HANDLE_W-1:0] handles [SLOTS],
	input  wire logic [KEY_W-1:0]    lru_key,
	output lkv_cell_cmd_t            cmd [SLOTS],
	output logic [HANDLE_W-1:0]      new_handle,
	output lkv_rsp_t                 rsp
);

	logic [SLOTS-1:0]    eq_k;
	logic [SLOTS-1:0]    eq_l;
	logic [SLOTS-1:0]    pre_k;
	logic [SLOTS-1:0]    pre_l;
	logic [SLOTS-1:0]    cand;
	logic [SLOTS-1:0]    pre_c;
	logic [SLOTS-1:0]    first_k;
	logic [SLOTS-1:0]    first_l;
	logic                hit;
	logic [HANDLE_W-1:0] hit_handle;

	// prefix chains marking whether an earlier slot already matched
	assign pre_k[0] = 1'b0;
	assign pre_l[0] = 1'b0;
	assign pre_c[0] = 1'b0;
	assign cand[0]  = 1'b0;

	for (genvar i = 0; i < SLOTS; i++) begin : g_flags
		assign eq_k[i]    = stat[i].eq_key;
		assign eq_l[i]    = stat[i].eq_lru;
		assign first_k[i] = eq_k[i] & ~pre_k[i];
		assign first_l[i] = eq_l[i] & ~pre_l[i];
		if (i > 0) begin : g_pre
			assign pre_k[i] = pre_k[i-1] | eq_k[i-1];
			assign pre_l[i] = pre_l[i-1] | eq_l[i-1];
			assign pre_c[i] = pre_c[i-1] | cand[i-1];
			// marks slots from one upward holding the key, or the overwrite slot
			assign cand[i]  = first_l[i] | eq_k[i];
		end
	end

	assign hit = |eq_k;

	// handle of the first matching slot
	always_comb begin
		hit_handle = '0;
		for (int i = 0; i < SLOTS; i++) begin
			hit_handle = hit_handle | (handles[i] & {HANDLE_W{first_k[i]}});
		end
	end

	assign new_handle = (lkv_op_t'(req.op) == OP_ADD) ? req.image_handle : hit_handle;

	// per-slot commands and the result beat
	always_comb begin
		for (int j = 0; j < SLOTS; j++) begin
			cmd[j] = '0;
		end
		rsp = '0;
		case (lkv_op_t'(req.op))
			OP_LOOKUP: begin
				rsp.found         = hit;
				rsp.result_handle = hit_handle;
				for (int j = 0; j < SLOTS; j++) begin
					cmd[j].take_prev = accept & hit & ~pre_k[j];
				end
			end
			OP_ADD: begin
				rsp.evicted_key = lru_key;
				if (eq_l[0]) begin
					// least recent key also sits in front: overwrite slot zero only
					cmd[0].take_new = accept;
				end else if (eq_k[0]) begin
					// front already holds the key: overwrite in place
					for (int j = 0; j < SLOTS; j++) begin
						cmd[j].take_new = accept & first_l[j];
					end
				end else begin
					for (int j = 0; j < SLOTS; j++) begin
						cmd[j].take_prev = accept & ~pre_c[j];
						cmd[j].take_new  = accept & first_l[j] & pre_c[j];
					end
				end
			end
			OP_CLEAR: begin
				for (int j = 0; j < SLOTS; j++) begin
					cmd[j].clr = accept;
				end
			end
			default: begin
				rsp = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== src/lru_key_value_table_top.sv =====
`default_nettype none

// Recency-ordered key/handle table of SLOTS entries, most recent in slot zero.
// A request beat is taken whenever start is high; busy never rises, so one beat
// can be issued every clock. Each beat yields exactly one result beat, shown on
// rsp with done high for the single cycle right after the accepting edge; the
// receiver must capture it then. A lookup, add or clear takes effect at that
// edge: every slot cell compares its key against the request and the least
// recent key in parallel, and the cells from the front up to the chosen slot
// take their front neighbour's pair along the chain in the same edge, so the
// compare and priority pick across SLOTS cells sets the cycle time. Reset and
// a clear leave every slot holding key zero, handle zero.

module lru_key_value_table_top
	import lkv_pkg::*;
#(
	parameter int unsigned SLOTS = 4
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire lkv_req_t req,
	output logic          done,
	output lkv_rsp_t      rsp
);

	lkv_cell_cmd_t       cmd [SLOTS];
	lkv_cell_stat_t      stat [SLOTS];
	logic [KEY_W-1:0]    slot_key [SLOTS];
	logic [HANDLE_W-1:0] slot_handle [SLOTS];
	logic [HANDLE_W-1:0] new_handle;
	lkv_rsp_t            rsp_d;
	lkv_rsp_t            rsp_q;
	logic                done_q;
	logic                accept;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// command decode and priority pick
	lkv_ctrl #(
		.SLOTS (SLOTS)
	) u_ctrl (
		.accept     (accept),
		.req        (req),
		.stat       (stat),
		.handles    (slot_handle),
		.lru_key    (slot_key[SLOTS-1]),
		.cmd        (cmd),
		.new_handle (new_handle),
		.rsp        (rsp_d)
	);

	// row of slot cells, each fed by its front neighbour
	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		logic [KEY_W-1:0]    prev_key;
		logic [HANDLE_W-1:0] prev_handle;
		if (i == 0) begin : g_head
			assign prev_key    = req.key;
			assign prev_handle = new_handle;
		end else begin : g_body
			assign prev_key    = slot_key[i-1];
			assign prev_handle = slot_handle[i-1];
		end
		lkv_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.key         (req.key),
			.lru_key     (slot_key[SLOTS-1]),
			.new_handle  (new_handle),
			.prev_key    (prev_key),
			.prev_handle (prev_handle),
			.cmd         (cmd[i]),
			.stat        (stat[i]),
			.slot_key    (slot_key[i]),
			.slot_handle (slot_handle[i])
		);
	end

	// result register and strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

`default_nettype wire

// ===== tb/tb_lru_key_value_table_top.sv =====
`timescale 1ns / 1ps

module tb_lru_key_value_table_top;
	import lkv_pkg::*;

	localparam int unsigned SLOTS = 4;
	localparam int unsigned POOL_N = 6;
	localparam int unsigned RANDOM_ITEMS = 1580;
	localparam int unsigned BURST_LEN = 40;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [KEY_W-1:0] KEY_ONES = '1;
	localparam logic [HANDLE_W-1:0] HANDLE_ONES = '1;

	// recency table predictor and queue of expected result beats
	class lru_table_scoreboard;
		logic [KEY_W-1:0] slot_key [SLOTS];
		logic [HANDLE_W-1:0] slot_handle [SLOTS];
		lkv_rsp_t expected_q [$];
		int unsigned fail_count;

		function new();
			fail_count = 0;
			clear_slots();
		endfunction

		function void clear_slots();
			for (int unsigned i = 0; i < SLOTS; i++) begin
				slot_key[i] = '0;
				slot_handle[i] = '0;
			end
		endfunction

		// shift slots ahead of pos back by one and put the pair in slot zero
		function void move_to_front(int unsigned pos, logic [KEY_W-1:0] k,
				logic [HANDLE_W-1:0] h);
			for (int unsigned j = pos; j > 0; j--) begin
				slot_key[j] = slot_key[j-1];
				slot_handle[j] = slot_handle[j-1];
			end
			slot_key[0] = k;
			slot_handle[0] = h;
		endfunction

		// work out the result of an accepted request beat
		function void note_request(lkv_req_t beat);
			lkv_rsp_t exp_rsp;
			logic [KEY_W-1:0] lru_key;
			int unsigned hit_pos;
			int unsigned dup_pos;
			exp_rsp = '0;
			case (beat.op)
				OP_LOOKUP: begin
					for (int unsigned i = 0; i < SLOTS; i++) begin
						if (slot_key[i] == beat.key) begin
							exp_rsp.found = 1'b1;
							exp_rsp.result_handle = slot_handle[i];
							if (i != 0)
								move_to_front(i, beat.key, slot_handle[i]);
							break;
						end
					end
				end
				OP_ADD: begin
					lru_key = slot_key[SLOTS-1];
					exp_rsp.evicted_key = lru_key;
					hit_pos = SLOTS - 1;
					for (int unsigned i = 0; i < SLOTS; i++) begin
						if (slot_key[i] == lru_key) begin
							hit_pos = i;
							break;
						end
					end
					slot_key[hit_pos] = beat.key;
					slot_handle[hit_pos] = beat.image_handle;
					// slot zero already holding the key stops any further shift
					if (slot_key[0] != beat.key) begin
						dup_pos = hit_pos;
						for (int unsigned i = 1; i < SLOTS; i++) begin
							if (slot_key[i] == beat.key) begin
								dup_pos = i;
								break;
							end
						end
						move_to_front(dup_pos, beat.key, beat.image_handle);
					end
				end
				OP_CLEAR: clear_slots();
				default: ;
			endcase
			expected_q.push_back(exp_rsp);
		endfunction

		// compare a result beat with the oldest expectation
		function void check_result(lkv_rsp_t got);
			lkv_rsp_t exp_rsp;
			if (expected_q.size() == 0) begin
				$error("result beat with nothing expected: %h", got);
				fail_count++;
				return;
			end
			exp_rsp = expected_q.pop_front();
			if (got.found !== exp_rsp.found) begin
				$error("found: expected %0d, actual %0d", exp_rsp.found, got.found);
				fail_count++;
			end
			if (got.result_handle !== exp_rsp.result_handle) begin
				$error("result_handle: expected %h, actual %h",
					exp_rsp.result_handle, got.result_handle);
				fail_count++;
			end
			if (got.evicted_key !== exp_rsp.evicted_key) begin
				$error("evicted_key: expected %h, actual %h",
					exp_rsp.evicted_key, got.evicted_key);
				fail_count++;
			end
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	lkv_req_t req;
	logic done;
	lkv_rsp_t rsp;

	lru_table_scoreboard sb;
	logic [KEY_W-1:0] key_pool [POOL_N];

	lru_key_value_table_top #(
		.SLOTS(SLOTS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	// clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// watchdog
	initial begin
		#20_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// check result beats, then note accepted request beats
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result(rsp);
			if (start && !busy)
				sb.note_request(req);
		end
	end

	// drive one request beat after a gap; from_slot >= 0 takes the key from the table
	task automatic send_beat(input logic [1:0] op, input logic [KEY_W-1:0] key,
			input logic [HANDLE_W-1:0] handle, input int from_slot, input int gap);
		lkv_req_t beat;
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		beat.op = op;
		beat.key = (from_slot >= 0) ? sb.slot_key[from_slot] : key;
		beat.image_handle = handle;
		req <= beat;
		start <= 1'b1;
		do @(posedge clk); while (busy);
	endtask

	// idle length: mostly short, now and then long
	function automatic int pick_gap(input bit no_idle);
		int unsigned r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	// key from the pool, zero, an extreme or fully random
	function automatic logic [KEY_W-1:0] pick_key();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return key_pool[$urandom_range(0, POOL_N-1)];
		else if (r < 80)
			return '0;
		else if (r < 85)
			return KEY_ONES;
		else
			return {$urandom, $urandom};
	endfunction

	function automatic logic [HANDLE_W-1:0] pick_handle();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return '0;
		else if (r < 14)
			return HANDLE_ONES;
		else
			return $urandom;
	endfunction

	initial begin
		int unsigned r;
		int from_slot;
		bit no_idle;
		logic [1:0] op;

		sb = new();
		for (int unsigned i = 0; i < POOL_N; i++)
			key_pool[i] = {$urandom, $urandom};
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty-slot match, misses, fills, duplicates, key zero, clear
		send_beat(OP_LOOKUP, '0, '0, -1, 1);
		send_beat(OP_LOOKUP, KEY_ONES, HANDLE_ONES, -1, 0);
		send_beat(OP_ADD, KEY_ONES, HANDLE_ONES, -1, 0);
		send_beat(OP_ADD, 64'd1, '0, -1, 0);
		send_beat(OP_ADD, 64'h8000_0000_0000_0000, 32'h8000_0000, -1, 2);
		send_beat(OP_ADD, 64'h5555_5555_5555_5555, 32'h5555_5555, -1, 0);
		send_beat(OP_ADD, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA, -1, 0);
		send_beat(OP_LOOKUP, 64'd1, '0, -1, 0);
		send_beat(OP_LOOKUP, 64'h5555_5555_5555_5555, '0, -1, 3);
		send_beat(OP_LOOKUP, '0, '0, -1, 0);
		send_beat(OP_ADD, 64'h5555_5555_5555_5555, 32'h0000_00FF, -1, 0);
		send_beat(OP_ADD, 64'd1, 32'h0000_0F0F, -1, 0);
		send_beat(OP_ADD, '0, 32'h0000_1234, -1, 0);
		send_beat(OP_LOOKUP, '0, '0, -1, 1);
		send_beat(OP_LOOKUP, 64'd1, '0, -1, 0);
		send_beat(OP_UNUSED, KEY_ONES, HANDLE_ONES, -1, 0);
		send_beat(OP_LOOKUP, '0, '0, SLOTS - 1, 0);
		send_beat(OP_CLEAR, KEY_ONES, HANDLE_ONES, -1, 0);
		send_beat(OP_LOOKUP, '0, '0, -1, 0);
		send_beat(OP_ADD, KEY_ONES, HANDLE_ONES, -1, 0);
		send_beat(OP_ADD, KEY_ONES, '0, -1, 0);
		send_beat(OP_LOOKUP, KEY_ONES, '0, -1, 0);

		// random: bursts of back-to-back beats mixed at random with idled ones
		for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % BURST_LEN == 0) begin
				no_idle = ($urandom_range(0, 2) == 0);
				// let the table drain completely now and then
				if (n % (BURST_LEN * 10) == 0) begin
					@(negedge clk);
					start <= 1'b0;
					while (sb.pending() != 0)
						@(negedge clk);
				end
			end
			r = $urandom_range(0, 99);
			if (r < 47)
				op = OP_LOOKUP;
			else if (r < 90)
				op = OP_ADD;
			else if (r < 95)
				op = OP_CLEAR;
			else
				op = OP_UNUSED;
			from_slot = -1;
			if (op == OP_LOOKUP && $urandom_range(0, 99) < 35)
				from_slot = $urandom_range(0, SLOTS - 1);
			else if (op == OP_ADD && $urandom_range(0, 99) < 20)
				from_slot = $urandom_range(0, SLOTS - 1);
			send_beat(op, pick_key(), pick_handle(), from_slot, pick_gap(no_idle));
		end

		// drain and settle
		@(negedge clk);
		start <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (5) @(negedge clk);
		if (sb.fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/lkv_pkg.sv
src/lkv_cell.sv
src/lkv_ctrl.sv
src/lru_key_value_table_top.sv
tb/tb_lru_key_value_table_top.sv
